>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/vtx_pkg.sv
// ----------------------------------------------------------------------------
// vtx_pkg
// shared widths and types for the 4x4 vertex transform pipeline
// ----------------------------------------------------------------------------
package vtx_pkg;

  localparam int CompW    = 32;
  localparam int NumComp  = 4;
  localparam int NumEntry = NumComp * NumComp;
  localparam int NumRegs  = NumEntry / 2;
  localparam int RegW     = 2 * CompW;
  localparam int FracW    = 16;
  localparam int ShW      = 2 * CompW - FracW;  // product after >>> 16
  localparam int PairW    = ShW + 1;            // sum of two products
  localparam int SumW     = ShW + 2;            // sum of four products
  localparam int RegIdxW  = $clog2(NumRegs);
  localparam int AddrW    = RegIdxW + 3;        // 8-byte register spacing
  localparam int WordW    = NumComp * CompW;

  typedef logic signed [CompW-1:0] comp_t;
  typedef comp_t                   vec_t [NumComp];
  typedef comp_t                   mat_t [NumEntry];
  typedef logic signed [ShW-1:0]   prod_t;
  typedef prod_t                   prod_arr_t [NumEntry];
  typedef logic signed [SumW-1:0]  sum_t;
  typedef sum_t                    sum_vec_t [NumComp];
  typedef logic [RegW-1:0]         reg_word_t;

  localparam comp_t CompMax = {1'b0, {(CompW-1){1'b1}}};
  localparam comp_t CompMin = {1'b1, {(CompW-1){1'b0}}};
  localparam comp_t OneQ    = comp_t'(1) <<< FracW;

endpackage

>>> hw/rtl/vtx_mul.sv
// ----------------------------------------------------------------------------
// vtx_mul
// stage 1: sixteen 32x32 signed products, each kept as product >>> 16
// ----------------------------------------------------------------------------
module vtx_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  vtx_pkg::vec_t in_vec,
  input  vtx_pkg::mat_t mat,
  output logic          out_valid,
  input  logic          out_ready,
  output vtx_pkg::prod_arr_t out_prod
);
  import vtx_pkg::*;

  logic      valid_r;
  logic      adv;
  prod_arr_t prod_r;
  prod_arr_t prod_nxt;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;

  // slot r*4+c holds entry(c*4+r) * v[c]; upper bits are the floor shift
  always_comb begin
    logic signed [2*CompW-1:0] p;
    for (int r = 0; r < NumComp; r++) begin
      for (int c = 0; c < NumComp; c++) begin
        p = (2*CompW)'(mat[c*NumComp+r]) * (2*CompW)'(in_vec[c]);
        prod_nxt[r*NumComp+c] = p[2*CompW-1:FracW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prod  = prod_r;

endmodule

>>> hw/rtl/vtx_sum.sv
// ----------------------------------------------------------------------------
// vtx_sum
// stages 2 and 3: registered adder tree, four products per row
// ----------------------------------------------------------------------------
module vtx_sum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vtx_pkg::prod_arr_t in_prod,
  output logic               out_valid,
  input  logic               out_ready,
  output vtx_pkg::sum_vec_t  out_sum
);
  import vtx_pkg::*;

  typedef logic signed [PairW-1:0] pair_t;
  typedef pair_t                   pair_arr_t [2*NumComp];

  logic      pair_valid_r;
  logic      sum_valid_r;
  logic      pair_adv;
  logic      sum_adv;
  pair_arr_t pair_r;
  pair_arr_t pair_nxt;
  sum_vec_t  sum_r;
  sum_vec_t  sum_nxt;

  assign sum_adv  = !sum_valid_r || out_ready;
  assign pair_adv = !pair_valid_r || sum_adv;
  assign in_ready = pair_adv;

  always_comb begin
    for (int i = 0; i < 2*NumComp; i++) begin
      pair_nxt[i] = PairW'(in_prod[2*i]) + PairW'(in_prod[2*i+1]);
    end
    for (int r = 0; r < NumComp; r++) begin
      sum_nxt[r] = SumW'(pair_r[2*r]) + SumW'(pair_r[2*r+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_valid_r <= 1'b0;
      sum_valid_r  <= 1'b0;
    end else begin
      if (pair_adv) begin
        pair_valid_r <= in_valid;
      end
      if (sum_adv) begin
        sum_valid_r <= pair_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_adv && in_valid) begin
      pair_r <= pair_nxt;
    end
    if (sum_adv && pair_valid_r) begin
      sum_r <= sum_nxt;
    end
  end

  assign out_valid = sum_valid_r;
  assign out_sum   = sum_r;

endmodule

>>> hw/rtl/vtx_sat.sv
// ----------------------------------------------------------------------------
// vtx_sat
// stage 4: clamp each row to 32 bits, flag overflow, hold the output word
// ----------------------------------------------------------------------------
module vtx_sat (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vtx_pkg::sum_vec_t          in_sum,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [vtx_pkg::WordW-1:0]  out_data,
  output logic                       out_ovf
);
  import vtx_pkg::*;

  logic             valid_r;
  logic             adv;
  logic [WordW-1:0] data_r;
  logic [WordW-1:0] data_nxt;
  logic             ovf_r;
  logic             ovf_nxt;

  assign adv      = !valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    logic hi_ones;
    logic hi_zeros;
    ovf_nxt = 1'b0;
    for (int r = 0; r < NumComp; r++) begin
      // bits above the sign bit of a 32-bit value must all match it
      hi_ones  = &in_sum[r][SumW-1:CompW-1];
      hi_zeros = ~|in_sum[r][SumW-1:CompW-1];
      if (hi_ones || hi_zeros) begin
        data_nxt[r*CompW +: CompW] = in_sum[r][CompW-1:0];
      end else begin
        ovf_nxt = 1'b1;
        data_nxt[r*CompW +: CompW] = in_sum[r][SumW-1] ? CompMin : CompMax;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      data_r <= data_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;
  assign out_ovf   = ovf_r;

endmodule

>>> hw/rtl/vertex_transform_4x4_unit.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4_unit
// 4x4 matrix times homogeneous vector in Q16.16, saturated, 4-stage pipeline
// ----------------------------------------------------------------------------
//   channel  | direction | payload
//   in_*     | stream in | tdata = x, y, z, w (32 bits each, x lowest)
//   out_*    | stream out| tdata = x, y, z, w; tuser = overflow
//   cfg_*    | apb slave | mat_pair_0..7 at byte address 8*i, 64-bit data
//
// one word per cycle sustained while out_tready stays high; each word
// passes four register stages in order: multiply, two adder levels,
// clamp.
// each stage advances when it is empty or the one after it advances, so
// bubbles close up and a stall on out_tready holds every word in place.
// rst_n clears the stage valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  // input word
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [vtx_pkg::WordW-1:0]    in_tdata,    // x, y, z, w from bit 0 up
  // result word
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [vtx_pkg::WordW-1:0]    out_tdata,   // x, y, z, w from bit 0 up
  output logic                         out_tuser,   // overflow
  // configuration
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [vtx_pkg::AddrW-1:0]    cfg_paddr,
  input  logic [vtx_pkg::RegW-1:0]     cfg_pwdata,
  output logic [vtx_pkg::RegW-1:0]     cfg_prdata,
  output logic                         cfg_pready
);
  import vtx_pkg::*;

  reg_word_t            mat_r [NumRegs];
  logic                 cfg_wr;
  logic [RegIdxW-1:0]   cfg_idx;
  mat_t                 mat;
  vec_t                 in_vec;

  logic      mul_valid;
  logic      mul_ready;
  prod_arr_t mul_prod;
  logic      sum_valid;
  logic      sum_ready;
  sum_vec_t  sum_vec;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[AddrW-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = mat_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // identity: diagonal entries 0, 5, 10, 15
      mat_r[0] <= RegW'(OneQ);
      mat_r[1] <= '0;
      mat_r[2] <= {OneQ, comp_t'(0)};
      mat_r[3] <= '0;
      mat_r[4] <= '0;
      mat_r[5] <= RegW'(OneQ);
      mat_r[6] <= '0;
      mat_r[7] <= {OneQ, comp_t'(0)};
    end else if (cfg_wr) begin
      mat_r[cfg_idx] <= cfg_pwdata;
    end
  end

  always_comb begin
    for (int k = 0; k < NumRegs; k++) begin
      mat[2*k]   = mat_r[k][CompW-1:0];
      mat[2*k+1] = mat_r[k][RegW-1:CompW];
    end
    for (int c = 0; c < NumComp; c++) begin
      in_vec[c] = in_tdata[c*CompW +: CompW];
    end
  end

  vtx_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_vec    (in_vec),
    .mat       (mat),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_prod  (mul_prod)
  );

  vtx_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_prod   (mul_prod),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_sum   (sum_vec)
  );

  vtx_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_sum    (sum_vec),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_ovf   (out_tuser)
  );

endmodule

>>> hw/rtl/vtx_checker.sv
// ----------------------------------------------------------------------------
// vtx_checker
// port-level checks for the vertex transform unit, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vtx_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [vtx_pkg::WordW-1:0] out_tdata,
  input logic                      out_tuser,
  input logic                      cfg_pready
);
  import vtx_pkg::*;

  logic       in_acc;
  logic       out_stall;
  logic       sat_seen;
  logic       flow_4;
  logic [3:0] acc_hist_r;
  logic [2:0] rdy_hist_r;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  always_comb begin
    sat_seen = 1'b0;
    for (int r = 0; r < NumComp; r++) begin
      if (out_tdata[r*CompW +: CompW] == CompMax ||
          out_tdata[r*CompW +: CompW] == CompMin) begin
        sat_seen = 1'b1;
      end
    end
  end

  // accept and ready history, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_hist_r <= '0;
      rdy_hist_r <= '0;
    end else begin
      acc_hist_r <= {acc_hist_r[2:0], in_acc};
      rdy_hist_r <= {rdy_hist_r[1:0], out_tready};
    end
  end

  // oldest accepted word in the history, with out_tready high in every sample
  assign flow_4 = acc_hist_r[3] && (&rdy_hist_r);

  `ASSERT_ALWAYS(a_pready_high, clk, rst_n, cfg_pready, "cfg_pready dropped")
  `ASSERT_IMPL(a_ovf_means_clamp, clk, rst_n, out_tvalid && out_tuser, sat_seen, "ovf, no clamp")
  `ASSERT_IMPL(a_latency, clk, rst_n, flow_4, out_tvalid, "result late after accept")
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable({out_tuser, out_tdata}), "held")

endmodule

bind vertex_transform_4x4_unit vtx_checker u_vtx_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_pready (cfg_pready)
);

>>> tb/vertex_transform_4x4_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4_unit_test
// self-checking bench for the Q16.16 4x4 matrix times vector pipeline
// ----------------------------------------------------------------------------
// Vectors stream in from a queue through a clocked driver. A monitor predicts
// each transformed word when the input is accepted and compares every output
// word field by field. The matrix is reloaded over APB between phases and
// read back. Phases mix directed corner vectors, saturating matrices, random
// data, sender gaps, receiver stalls and two long output hold-offs.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_unit_test;
  import vtx_pkg::*;

  localparam int CycleLimit    = 400_000;
  localparam int DrainCycles   = 8;
  localparam int HoldoffCycles = 80;
  localparam int MaxReports    = 50;

  typedef struct packed {
    comp_t w;
    comp_t z;
    comp_t y;
    comp_t x;
  } vertex_t;

  typedef struct packed {
    logic  ovf;
    comp_t w;
    comp_t z;
    comp_t y;
    comp_t x;
  } xform_t;

  typedef enum {
    MAT_IDENTITY, MAT_HALF, MAT_ALL_MAX, MAT_ALL_MIN, MAT_ZERO,
    MAT_NEG_LSB, MAT_SMALL, MAT_FULL, MAT_EXTREME
  } mat_kind_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [WordW-1:0]   in_tdata = '0;     // x, y, z, w from bit 0 up
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [WordW-1:0]   out_tdata;         // x, y, z, w from bit 0 up
  logic               out_tuser;         // overflow
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [AddrW-1:0]   cfg_paddr = '0;
  logic [RegW-1:0]    cfg_pwdata = '0;
  logic [RegW-1:0]    cfg_prdata;
  logic               cfg_pready;

  vertex_t pending_vertices[$];
  xform_t  expected_xforms[$];
  comp_t   mat_entry [NumEntry];
  xform_t  oldest_xform;
  xform_t  seen_xform;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_requests = 0;
  int holdoff_served = 0;
  int holdoff_left = 0;
  int mismatches = 0;
  int words_seen = 0;
  int saturated_seen = 0;
  int settings_used = 1;
  int cycle_count = 0;

  vertex_transform_4x4_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_xforms.size());
      $display("FAIL vertex_transform_4x4_unit");
      $finish;
    end
  end

  // matrix entry col*4+row, each product floored by the shift, sum clamped
  function automatic xform_t transform_vertex(vertex_t v);
    comp_t  comps [NumComp];
    comp_t  rows [NumComp];
    longint acc;
    logic   ovf;
    xform_t r;
    comps = '{v.x, v.y, v.z, v.w};
    ovf = 1'b0;
    for (int row = 0; row < NumComp; row++) begin
      acc = 0;
      for (int col = 0; col < NumComp; col++)
        acc += (longint'(mat_entry[col*NumComp+row]) * longint'(comps[col])) >>> FracW;
      if (acc > longint'(CompMax)) begin
        rows[row] = CompMax;
        ovf = 1'b1;
      end else if (acc < longint'(CompMin)) begin
        rows[row] = CompMin;
        ovf = 1'b1;
      end else begin
        rows[row] = comp_t'(acc);
      end
    end
    r.x = rows[0];
    r.y = rows[1];
    r.z = rows[2];
    r.w = rows[3];
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_field(string name, logic [CompW-1:0] want, logic [CompW-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // driver: a new word goes out once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_vertices.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tdata  <= pending_vertices.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (holdoff_served != holdoff_requests) begin
      holdoff_served = holdoff_requests;
      holdoff_left = HoldoffCycles;
      out_tready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_xforms.push_back(transform_vertex(vertex_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        seen_xform = xform_t'({out_tuser, out_tdata});
        words_seen++;
        if (seen_xform.ovf === 1'b1)
          saturated_seen++;
        if (expected_xforms.size() == 0) begin
          mismatches++;
          $display("%0t ns: unexpected word, expected none, got %h",
                   $time, seen_xform);
        end else begin
          oldest_xform = expected_xforms.pop_front();
          report_field("x", oldest_xform.x, seen_xform.x);
          report_field("y", oldest_xform.y, seen_xform.y);
          report_field("z", oldest_xform.z, seen_xform.z);
          report_field("w", oldest_xform.w, seen_xform.w);
          report_field("overflow", CompW'(oldest_xform.ovf), CompW'(seen_xform.ovf));
        end
      end
    end
  end

  // one apb transfer; a read is checked against the local matrix copy
  task automatic apb_transfer(int idx, bit is_write, reg_word_t wdata);
    reg_word_t held;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= AddrW'(idx * 8);
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    held = {mat_entry[2*idx+1], mat_entry[2*idx]};
    if (is_write) begin
      mat_entry[2*idx]   = wdata[CompW-1:0];
      mat_entry[2*idx+1] = wdata[RegW-1:CompW];
    end else if (cfg_prdata !== held) begin
      mismatches++;
      $display("%0t ns: mat_pair_%0d readback, expected %h, got %h",
               $time, idx, held, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic comp_t pick_entry(mat_kind_e kind, int k);
    bit diag;
    diag = (k % (NumComp + 1)) == 0;
    case (kind)
      MAT_IDENTITY: return diag ? OneQ : comp_t'(0);
      MAT_HALF:     return diag ? comp_t'(32'h0000_8000) : comp_t'(32'hFFFF_C000);
      MAT_ALL_MAX:  return CompMax;
      MAT_ALL_MIN:  return CompMin;
      MAT_ZERO:     return comp_t'(0);
      MAT_NEG_LSB:  return comp_t'(-1);
      MAT_SMALL:    return comp_t'($urandom_range(32'h0004_0000) - 32'h0002_0000);
      MAT_FULL:     return comp_t'($urandom);
      default: begin
        case ($urandom_range(6))
          0: return CompMax;
          1: return CompMin;
          2: return comp_t'(0);
          3: return comp_t'(-1);
          4: return OneQ;
          5: return -OneQ;
          default: return comp_t'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return comp_t'($urandom);
      5, 6, 7:       return comp_t'($urandom_range(32'h0080_0000) - 32'h0040_0000);
      8: begin
        case ($urandom_range(3))
          0: return CompMax;
          1: return CompMin;
          2: return OneQ;
          default: return -OneQ;
        endcase
      end
      default:       return comp_t'($urandom_range(2) - 1);
    endcase
  endfunction

  function automatic vertex_t make_vertex(comp_t x, comp_t y, comp_t z, comp_t w);
    return vertex_t'({w, z, y, x});
  endfunction

  task automatic load_matrix(mat_kind_e kind);
    comp_t lo;
    comp_t hi;
    for (int i = 0; i < NumRegs; i++) begin
      lo = pick_entry(kind, 2*i);
      hi = pick_entry(kind, 2*i + 1);
      apb_transfer(i, 1'b1, {hi, lo});
    end
    for (int i = 0; i < NumRegs; i++)
      apb_transfer(i, 1'b0, '0);
    settings_used++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_vertices.size() != 0 || in_tvalid || expected_xforms.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_random_phase(mat_kind_e kind, int send_pct, int stall_pct,
                                  int n_items, bit squeeze);
    load_matrix(kind);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < n_items; n++)
      pending_vertices.push_back(make_vertex(rand_comp(), rand_comp(), rand_comp(),
                                             rand_comp()));
    if (squeeze) begin
      repeat (20) @(posedge clk);
      @(negedge clk) holdoff_requests++;
    end
    wait_drained();
  endtask

  initial begin
    for (int k = 0; k < NumEntry; k++)
      mat_entry[k] = (k % (NumComp + 1) == 0) ? OneQ : comp_t'(0);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // identity after reset: values pass through unchanged
    for (int i = 0; i < NumRegs; i++)
      apb_transfer(i, 1'b0, '0);
    pending_vertices.push_back(make_vertex(0, 0, 0, 0));
    pending_vertices.push_back(make_vertex(CompMax, CompMax, CompMax, CompMax));
    pending_vertices.push_back(make_vertex(CompMin, CompMin, CompMin, CompMin));
    pending_vertices.push_back(make_vertex(-1, -1, -1, -1));
    pending_vertices.push_back(make_vertex(OneQ, -OneQ, CompMax, CompMin));
    pending_vertices.push_back(make_vertex(32'hAAAA_AAAA, 32'h5555_5555,
                                           32'h0F0F_0F0F, 32'hF0F0_F0F0));
    pending_vertices.push_back(make_vertex(32'h5555_5555, 32'hAAAA_AAAA,
                                           32'hF0F0_F0F0, 32'h0F0F_0F0F));
    wait_drained();

    // fractional entries: negative products must round toward minus infinity
    load_matrix(MAT_HALF);
    pending_vertices.push_back(make_vertex(-1, -1, -1, -1));
    pending_vertices.push_back(make_vertex(1, 1, 1, 1));
    pending_vertices.push_back(make_vertex(-3, 3, -5, 7));
    pending_vertices.push_back(make_vertex(CompMin, CompMax, -OneQ, OneQ));
    wait_drained();

    // saturation above and below, plus sums landing exactly on the limits
    load_matrix(MAT_ALL_MAX);
    pending_vertices.push_back(make_vertex(CompMax, CompMax, CompMax, CompMax));
    pending_vertices.push_back(make_vertex(CompMin, CompMin, CompMin, CompMin));
    pending_vertices.push_back(make_vertex(OneQ, 0, 0, 0));
    pending_vertices.push_back(make_vertex(0, 0, 0, 0));
    wait_drained();

    load_matrix(MAT_ALL_MIN);
    pending_vertices.push_back(make_vertex(OneQ, 0, 0, 0));
    pending_vertices.push_back(make_vertex(-OneQ, 0, 0, 0));
    pending_vertices.push_back(make_vertex(CompMax, CompMax, CompMax, CompMax));
    pending_vertices.push_back(make_vertex(CompMin, 1, -1, OneQ));
    wait_drained();

    run_random_phase(MAT_SMALL,    0,  0,  150, 1'b1);
    run_random_phase(MAT_FULL,     58, 0,  140, 1'b0);
    run_random_phase(MAT_SMALL,    0,  58, 140, 1'b0);
    run_random_phase(MAT_EXTREME,  13, 13, 140, 1'b0);
    run_random_phase(MAT_NEG_LSB,  13, 13, 40,  1'b0);
    run_random_phase(MAT_ZERO,     0,  58, 30,  1'b0);
    run_random_phase(MAT_IDENTITY, 58, 0,  60,  1'b0);
    run_random_phase(MAT_FULL,     0,  0,  100, 1'b1);

    $display("checked %0d transformed words over %0d matrix settings, %0d saturated",
             words_seen, settings_used, saturated_seen);
    $display("traffic mixed free flow, sender gaps, receiver stalls and a %0d-cycle hold-off",
             HoldoffCycles);
    if (mismatches == 0 && expected_xforms.size() == 0) begin
      $display("PASS vertex_transform_4x4_unit");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, expected_xforms.size());
      $display("FAIL vertex_transform_4x4_unit");
    end
    $finish;
  end

endmodule
